>>> rtl/core/bd2_pkg.sv
// Shared constants and types for the 2x2 box downsampler.
// No dependencies; used by bd2_line_ram and box_downsample_2x2_top.
`timescale 1ns / 1ps

package bd2_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int LINE_DEPTH   = (MAX_WIDTH + 1) / 2;

    localparam int CHAN_W = 8;
    localparam int SUM_W  = CHAN_W + 1;
    localparam int PAIR_W = 4 * SUM_W;
    localparam int CFG_W  = 13;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int SLOT_W = $clog2(LINE_DEPTH);

    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef logic [PAIR_W-1:0] t_pair;

endpackage

>>> rtl/core/bd2_line_ram.sv
// Line buffer of horizontal pair sums: one write port, one registered read port.
// Depends on bd2_pkg for depth and word width.
`timescale 1ns / 1ps

module bd2_line_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [bd2_pkg::SLOT_W-1:0] i_wr_addr,
    input  bd2_pkg::t_pair             i_wr_data,
    input  logic                       i_rd_en,
    input  logic [bd2_pkg::SLOT_W-1:0] i_rd_addr,
    output bd2_pkg::t_pair             o_rd_data
);

    bd2_pkg::t_pair r_mem [bd2_pkg::LINE_DEPTH];
    bd2_pkg::t_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/box_downsample_2x2_top.sv
// Top level of the 2x2 box-filter downsampler (one mipmap level, RGBA8).
// Depends on bd2_pkg and bd2_line_ram.
//
// Throughput: one source pixel per clock while the output is not stalled; the input
// stalls only when stage 1 holds a result and the output register is stalled.
// Pipeline: two register stages (line buffer read, then the final sum register); the
// pixel completing a 2x2 block loads stage 1, and its result moves into the output
// register once that register is free.
// Reset: counters cleared, src_width and src_height return to 1; the line
// buffer is not cleared, every entry is written before it is read in a frame.
`timescale 1ns / 1ps

module box_downsample_2x2_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // source pixel stream
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bd2_pkg::CHAN_W-1:0]  i_in_red,
    input  logic [bd2_pkg::CHAN_W-1:0]  i_in_green,
    input  logic [bd2_pkg::CHAN_W-1:0]  i_in_blue,
    input  logic [bd2_pkg::CHAN_W-1:0]  i_in_alpha,
    // downsampled pixel stream
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bd2_pkg::CHAN_W-1:0]  o_out_red,
    output logic [bd2_pkg::CHAN_W-1:0]  o_out_green,
    output logic [bd2_pkg::CHAN_W-1:0]  o_out_blue,
    output logic [bd2_pkg::CHAN_W-1:0]  o_out_alpha,
    output logic                        o_out_last
);

    localparam int CW = bd2_pkg::CHAN_W;
    localparam int SW = bd2_pkg::SUM_W;

    // configuration
    logic [bd2_pkg::CFG_W-1:0] r_src_width;
    logic [bd2_pkg::CFG_W-1:0] r_src_height;
    logic                      cfg_wr;
    logic [bd2_pkg::COL_W-1:0] w_col_last;
    logic [bd2_pkg::ROW_W-1:0] w_row_last;

    // frame position and held pixel
    logic [bd2_pkg::COL_W-1:0] r_col;
    logic [bd2_pkg::ROW_W-1:0] r_row;
    logic [bd2_pkg::COL_W-1:0] n_col;
    logic [bd2_pkg::ROW_W-1:0] n_row;
    logic [4*CW-1:0]           r_held;
    logic [4*CW-1:0]           w_pix;
    logic [4*CW-1:0]           w_left;

    // front stage
    logic                      in_acc;
    logic                      last_col;
    logic                      last_row;
    logic                      have_pair;
    logic                      odd_col;
    logic                      odd_row;
    logic                      wr_line;
    logic                      emit;
    bd2_pkg::t_pair            w_pair;
    logic [bd2_pkg::SLOT_W-1:0] w_slot;

    // stage 1 (line buffer read in flight)
    logic                      r_s1_valid;
    logic                      r_s1_use_mem;
    logic                      r_s1_last;
    bd2_pkg::t_pair            r_s1_pair;
    bd2_pkg::t_pair            ram_rd_data;
    bd2_pkg::t_pair            w_upper;
    logic                      out_free;
    logic                      s1_adv;
    logic [4*CW-1:0]           w_mean;

    // output register
    logic                      r_out_valid;
    logic                      r_out_last;
    logic [4*CW-1:0]           r_out_pix;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bd2_pkg::CFG_W'(1);
            r_src_height <= bd2_pkg::CFG_W'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                bd2_pkg::REG_SRC_WIDTH:  r_src_width  <= pwdata[bd2_pkg::CFG_W-1:0];
                bd2_pkg::REG_SRC_HEIGHT: r_src_height <= pwdata[bd2_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bd2_pkg::REG_SRC_WIDTH:  prdata = 32'(r_src_width);
            bd2_pkg::REG_SRC_HEIGHT: prdata = 32'(r_src_height);
            default:                 prdata = '0;
        endcase
    end

    // last column / row index, with 0 taken as 1 and large values clamped
    always_comb begin
        if (r_src_width == '0) begin
            w_col_last = '0;
        end else if (r_src_width > bd2_pkg::CFG_W'(bd2_pkg::MAX_WIDTH)) begin
            w_col_last = bd2_pkg::COL_W'(bd2_pkg::MAX_WIDTH - 1);
        end else begin
            w_col_last = bd2_pkg::COL_W'(r_src_width - bd2_pkg::CFG_W'(1));
        end
        if (r_src_height == '0) begin
            w_row_last = '0;
        end else if (r_src_height > bd2_pkg::CFG_W'(bd2_pkg::HEIGHT_LIMIT)) begin
            w_row_last = bd2_pkg::ROW_W'(bd2_pkg::HEIGHT_LIMIT - 1);
        end else begin
            w_row_last = bd2_pkg::ROW_W'(r_src_height - bd2_pkg::CFG_W'(1));
        end
    end

    // ---------------- front stage ----------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign w_pix    = {i_in_alpha, i_in_blue, i_in_green, i_in_red};
    assign last_col = (r_col == w_col_last);
    assign last_row = (r_row == w_row_last);
    assign odd_col  = r_col[0];
    assign odd_row  = r_row[0];
    assign have_pair = odd_col || last_col;
    assign w_slot   = r_col[bd2_pkg::COL_W-1:1];
    // odd width: the last even-column pixel pairs with itself
    assign w_left   = odd_col ? r_held : w_pix;
    assign wr_line  = in_acc && have_pair && !odd_row && !last_row;
    assign emit     = in_acc && have_pair && (odd_row || last_row);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_pair[c*SW +: SW] = SW'(w_left[c*CW +: CW]) + SW'(w_pix[c*CW +: CW]);
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + bd2_pkg::ROW_W'(1);
        end else begin
            n_col = r_col + bd2_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (in_acc && !odd_col && !last_col) begin
            r_held <= w_pix;
        end
    end

    bd2_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_line),
        .i_wr_addr (w_slot),
        .i_wr_data (w_pair),
        .i_rd_en   (emit && odd_row),
        .i_rd_addr (w_slot),
        .o_rd_data (ram_rd_data)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= emit;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_pair    <= w_pair;
            r_s1_use_mem <= odd_row;
            r_s1_last    <= last_col && last_row;
        end
    end

    // odd height on the last row: the pair is its own lower row
    assign w_upper = r_s1_use_mem ? ram_rd_data : r_s1_pair;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_mean[c*CW +: CW] = CW'(((SW+1)'(w_upper[c*SW +: SW])
                                    + (SW+1)'(r_s1_pair[c*SW +: SW])
                                    + (SW+1)'(2)) >> 2);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix  <= w_mean;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix[0*CW +: CW];
    assign o_out_green = r_out_pix[1*CW +: CW];
    assign o_out_blue  = r_out_pix[2*CW +: CW];
    assign o_out_alpha = r_out_pix[3*CW +: CW];
    assign o_out_last  = r_out_last;

endmodule

>>> sim/box_downsample_2x2_top_tb.sv
// Self-checking testbench for box_downsample_2x2_top: random RGBA frames, APB setup,
// a built-in 2x2 box-filter predictor and a scoreboard of expected mip pixels.
// Depends on bd2_pkg and the box_downsample_2x2_top RTL.
`timescale 1ns / 1ps

module box_downsample_2x2_top_tb;

    typedef logic [3:0][bd2_pkg::CHAN_W-1:0] t_rgba;      // [0] red .. [3] alpha
    typedef logic [3:0][bd2_pkg::SUM_W-1:0]  t_pair_sums;
    typedef struct {
        t_rgba mean;
        logic  last;
    } t_mip_pixel;

    localparam int RANDOM_PIXELS = 1100;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [2:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [bd2_pkg::CHAN_W-1:0] i_in_red = '0;
    logic [bd2_pkg::CHAN_W-1:0] i_in_green = '0;
    logic [bd2_pkg::CHAN_W-1:0] i_in_blue = '0;
    logic [bd2_pkg::CHAN_W-1:0] i_in_alpha = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [bd2_pkg::CHAN_W-1:0] o_out_red;
    logic [bd2_pkg::CHAN_W-1:0] o_out_green;
    logic [bd2_pkg::CHAN_W-1:0] o_out_blue;
    logic [bd2_pkg::CHAN_W-1:0] o_out_alpha;
    logic                       o_out_last;

    box_downsample_2x2_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_out_last  (o_out_last)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [bd2_pkg::CFG_W-1:0] cfg_width = 13'd1;
    logic [bd2_pkg::CFG_W-1:0] cfg_height = 13'd1;
    int                        col_pos = 0;
    int                        row_pos = 0;
    t_rgba                     held_pixel = '0;
    t_pair_sums                pair_line [bd2_pkg::LINE_DEPTH];

    t_rgba            pending_pixels [$];
    t_mip_pixel       mean_queue [$];
    int               error_count = 0;
    bit               gaps_on = 1'b0;
    bit               stalls_on = 1'b0;

    t_rgba directed_pixels [18] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0102_0304,
        32'h807F_01FE, 32'hAA55_AA55,
        32'h0101_0101, 32'h0202_0202, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0101_0101, 32'hFFFF_FFFF,
        32'h0303_0303, 32'h0000_0000, 32'h8080_8080,
        32'hFF00_FF00, 32'h00FF_00FF, 32'h0102_0304, 32'h7F80_FE01
    };

    function automatic int clamp_dim(input logic [bd2_pkg::CFG_W-1:0] raw, input int limit);
        if (raw == 0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    function automatic t_rgba random_pixel();
        t_rgba p;
        int    c;
        p = $urandom;
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            2: for (c = 0; c < 4; c++) p[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Fold one accepted source pixel into the predictor; queues a mip pixel when a block closes.
    task automatic fold_source_pixel(input t_rgba pix);
        int         w;
        int         h;
        int         slot;
        int         c;
        logic       last_col;
        logic       last_row;
        t_rgba      left;
        t_pair_sums pair;
        t_pair_sums upper;
        t_mip_pixel res;
        w = clamp_dim(cfg_width, bd2_pkg::MAX_WIDTH);
        h = clamp_dim(cfg_height, bd2_pkg::HEIGHT_LIMIT);
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        slot = col_pos / 2;
        // odd width: a lone last pixel pairs with itself
        left = (col_pos % 2 == 1) ? held_pixel : pix;
        for (c = 0; c < 4; c++)
            pair[c] = bd2_pkg::SUM_W'(left[c]) + bd2_pkg::SUM_W'(pix[c]);
        if (col_pos % 2 == 0 && !last_col) begin
            held_pixel = pix;
        end else if (row_pos % 2 == 0 && !last_row) begin
            pair_line[slot] = pair;
        end else begin
            // odd height: last even row stands in for its own lower row
            upper = (row_pos % 2 == 1) ? pair_line[slot] : pair;
            for (c = 0; c < 4; c++)
                res.mean[c] = bd2_pkg::CHAN_W'((11'(upper[c]) + 11'(pair[c]) + 11'd2) >> 2);
            res.last = last_col && last_row;
            mean_queue.insert(mean_queue.size(), res);
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic write_register(input logic reg_sel, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == bd2_pkg::REG_SRC_WIDTH)
            cfg_width = bd2_pkg::CFG_W'(value);
        else
            cfg_height = bd2_pkg::CFG_W'(value);
        // any register write restarts the frame
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic push_random_pixels(input int count);
        repeat (count) pending_pixels.insert(pending_pixels.size(), random_pixel());
    endtask

    task automatic push_directed(input int first, input int count);
        int i;
        for (i = first; i < first + count; i++)
            pending_pixels.insert(pending_pixels.size(), directed_pixels[i]);
    endtask

    // Wait until every pixel is taken and every mip pixel is back, then let the pipe settle.
    task automatic drain_block();
        while (pending_pixels.size() != 0 || i_in_valid || mean_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // source driver: bursts with random gaps when gaps are on, payload held while stalled
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_rgba next_pix;
        logic  taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken)
                fold_source_pixel({i_in_alpha, i_in_blue, i_in_green, i_in_red});
            if (!i_in_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    next_pix = pending_pixels.pop_front();
                    {i_in_alpha, i_in_blue, i_in_green, i_in_red} <= next_pix;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if (gaps_on) begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = $urandom_range(1, 5);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // sink stall pattern, stepped through bit by bit and refreshed after each full pass
    logic [15:0] stall_bits = '0;
    int          stall_pos = 0;
    always @(posedge i_clk) begin
        if (stall_pos == 0) begin
            case ($urandom_range(0, 7))
                0, 1, 2: stall_bits = 16'($urandom);
                3, 4, 5: stall_bits = 16'($urandom & $urandom);
                6:       stall_bits = 16'hFFFF;
                default: stall_bits = 16'h0000;
            endcase
        end
        i_out_stall <= stalls_on && stall_bits[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
    end

    // output monitor
    always @(posedge i_clk) begin
        t_mip_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mean_queue.size() == 0) begin
                report_mismatch("output transaction with nothing expected");
            end else begin
                want = mean_queue.pop_front();
                if (o_out_red !== want.mean[0])
                    report_mismatch($sformatf("out_red %0d, expected %0d", o_out_red,
                                              want.mean[0]));
                if (o_out_green !== want.mean[1])
                    report_mismatch($sformatf("out_green %0d, expected %0d", o_out_green,
                                              want.mean[1]));
                if (o_out_blue !== want.mean[2])
                    report_mismatch($sformatf("out_blue %0d, expected %0d", o_out_blue,
                                              want.mean[2]));
                if (o_out_alpha !== want.mean[3])
                    report_mismatch($sformatf("out_alpha %0d, expected %0d", o_out_alpha,
                                              want.mean[3]));
                if (o_out_last !== want.last)
                    report_mismatch($sformatf("out_last %0b, expected %0b", o_out_last,
                                              want.last));
            end
        end
    end

    initial begin
        int random_sent;
        int which;
        int w_raw;
        int h_raw;
        int frame;
        int n;
        random_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size is 1x1: each pixel comes straight back, flagged last
        push_directed(0, 3);
        drain_block();
        // zero sizes clamp to 1x1
        write_register(bd2_pkg::REG_SRC_WIDTH, 0);
        write_register(bd2_pkg::REG_SRC_HEIGHT, 0);
        push_directed(3, 2);
        drain_block();
        // odd width and height: duplicated last column and last row
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        write_register(bd2_pkg::REG_SRC_WIDTH, 3);
        write_register(bd2_pkg::REG_SRC_HEIGHT, 3);
        push_directed(5, 9);
        drain_block();
        write_register(bd2_pkg::REG_SRC_WIDTH, 2);
        write_register(bd2_pkg::REG_SRC_HEIGHT, 2);
        push_directed(14, 4);
        drain_block();

        // width clamps to max on a single row; only the start of the row is sent
        write_register(bd2_pkg::REG_SRC_WIDTH, 8191);
        write_register(bd2_pkg::REG_SRC_HEIGHT, 1);
        push_random_pixels(16);
        drain_block();
        // single column, height clamps to max; only the first rows are sent
        write_register(bd2_pkg::REG_SRC_WIDTH, 1);
        write_register(bd2_pkg::REG_SRC_HEIGHT, 8191);
        push_random_pixels(8);
        drain_block();
        // height clamps to max; only the first rows are sent
        write_register(bd2_pkg::REG_SRC_WIDTH, 2);
        write_register(bd2_pkg::REG_SRC_HEIGHT, 8191);
        push_random_pixels(8);
        drain_block();

        while (random_sent < RANDOM_PIXELS) begin
            which = (random_sent == 0) ? 0 : $urandom_range(0, 5);
            w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 9);
            h_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
            if (which != 1)
                write_register(bd2_pkg::REG_SRC_WIDTH, w_raw);
            if (which != 2)
                write_register(bd2_pkg::REG_SRC_HEIGHT, h_raw);
            frame = clamp_dim(cfg_width, bd2_pkg::MAX_WIDTH)
                  * clamp_dim(cfg_height, bd2_pkg::HEIGHT_LIMIT);
            n = frame * $urandom_range(1, 3);
            // sometimes leave a frame unfinished before the next setup
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, frame);
            if (n > RANDOM_PIXELS - random_sent)
                n = RANDOM_PIXELS - random_sent;
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            push_random_pixels(n);
            random_sent += n;
            drain_block();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
